// File: design/chm_pkg.sv
package chm_pkg;

    // Field widths of one beat on each channel
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 31;
    localparam int DATA_W = 32;

    // Default table geometry
    localparam int DEF_BUCKETS      = 1021;
    localparam int DEF_POOL_ENTRIES = 1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] data_value;
    } in_t;

    typedef struct packed {
        logic                     status;
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } out_t;

    // Status of the shared remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

// File: design/chm_ram.sv
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/chm_mod.sv
module chm_mod #(
    parameter int BUCKETS = chm_pkg::DEF_BUCKETS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [chm_pkg::KEY_W-1:0]    key,
    output chm_pkg::mod_stat_t           stat,
    output logic [$clog2(BUCKETS)-1:0]   remainder
);

    localparam int RW    = $clog2(BUCKETS);
    localparam int KW    = chm_pkg::KEY_W;
    localparam int SHIFT = KW + RW;
    localparam int MW    = KW + 32;
    // Reciprocal of the bucket count; the quotient estimate is exact or one short
    localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(BUCKETS));

    logic [KW-1:0] key_reg,   key_next;
    logic [KW-1:0] quo_reg,   quo_next;
    logic [RW:0]   part_reg,  part_next;
    logic [RW-1:0] rem_reg,   rem_next;
    logic          step1_reg, step1_next;
    logic          step2_reg, step2_next;
    logic          done_reg,  done_next;
    logic [MW-1:0] product;
    logic [KW-1:0] multiple;

    // Three stages: reciprocal multiply, multiply-subtract, compare-subtract
    always_comb begin
        key_next   = key_reg;
        quo_next   = quo_reg;
        part_next  = part_reg;
        rem_next   = rem_reg;
        step1_next = start;
        step2_next = step1_reg;
        done_next  = step2_reg;
        product    = MW'(key) * MW'(RECIP);
        multiple   = KW'(quo_reg * KW'(BUCKETS));

        // Capture the key and estimate the quotient
        if (start) begin
            key_next = key;
            quo_next = KW'(product >> SHIFT);
        end
        // Partial remainder, below twice the bucket count
        if (step1_reg) begin
            part_next = (RW+1)'(key_reg - multiple);
        end
        // One compare and subtract settles the remainder
        if (step2_reg) begin
            if (part_reg >= (RW+1)'(BUCKETS)) begin
                rem_next = RW'(part_reg - (RW+1)'(BUCKETS));
            end else begin
                rem_next = part_reg[RW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step1_reg <= 1'b0;
            step2_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            step1_reg <= step1_next;
            step2_reg <= step2_next;
            done_reg  <= done_next;
        end
        key_reg  <= key_next;
        quo_reg  <= quo_next;
        part_reg <= part_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = step1_reg || step2_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// File: design/chained_hash_map.sv
// Separate-chaining hash map from 31-bit keys to signed 32-bit values. Each
// beat on s_ carries a command (insert, lookup, clear) and yields exactly one
// result beat on m_. The bucket is key mod BUCKETS, computed by a shared
// three-stage remainder unit (reciprocal multiply, multiply-subtract, one
// compare-subtract). Insert runs from accept to the next accept through the
// hash, one bucket-memory read, one write into each of the bucket and entry
// memories, then the hand-off to the output register. Lookup visits chain
// entries one at a time, since the walk follows links through the single
// read port of the entry memory. A full pool answers an insert with status
// 1 and no hashing, and an unknown command goes straight to its response as
// well. Clear sweeps the bucket memory one bucket per cycle. After reset the
// same sweep runs with s_ready low. The block holds one item at a time; a
// finished result waits in the output register while the next item is
// taken, and the next result waits until that register is free.
module chained_hash_map #(
    parameter int BUCKETS      = chm_pkg::DEF_BUCKETS,
    parameter int POOL_ENTRIES = chm_pkg::DEF_POOL_ENTRIES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  chm_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output chm_pkg::out_t m_data
);

    localparam int RW = $clog2(BUCKETS);
    localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int FW = $clog2(POOL_ENTRIES + 1);
    localparam int BW = 1 + PW;
    localparam int EW = chm_pkg::KEY_W + chm_pkg::DATA_W + 1 + PW;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_BKT_CHK,
        ST_ENT_CHK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    state_t                           state_reg, state_next;
    logic [chm_pkg::CMD_W-1:0]        cmd_reg,   cmd_next;
    logic [chm_pkg::KEY_W-1:0]        key_reg,   key_next;
    logic signed [chm_pkg::DATA_W-1:0] data_reg, data_next;
    logic [RW-1:0]                    sweep_reg, sweep_next;
    logic [FW-1:0]                    fill_reg,  fill_next;
    chm_pkg::out_t                    res_reg,   res_next;
    logic                             m_valid_reg, m_valid_next;
    chm_pkg::out_t                    m_data_reg,  m_data_next;

    // Remainder unit
    logic                 mod_start;
    chm_pkg::mod_stat_t   mod_stat;
    logic [RW-1:0]        bucket;

    // Memory ports
    logic                 bkt_wr_en, bkt_rd_en;
    logic [RW-1:0]        bkt_wr_addr;
    logic [BW-1:0]        bkt_wr_data, bkt_rd_data;
    logic                 ent_wr_en, ent_rd_en;
    logic [PW-1:0]        ent_wr_addr, ent_rd_addr;
    logic [EW-1:0]        ent_wr_data, ent_rd_data;

    // Fields of the words read back
    logic                          bkt_live;
    logic [PW-1:0]                 bkt_head;
    logic [chm_pkg::KEY_W-1:0]     ent_key;
    logic [chm_pkg::DATA_W-1:0]    ent_value;
    logic                          ent_link_live;
    logic [PW-1:0]                 ent_link;
    logic                          s_beat;

    assign bkt_live      = bkt_rd_data[PW];
    assign bkt_head      = bkt_rd_data[PW-1:0];
    assign ent_key       = ent_rd_data[EW-1 -: chm_pkg::KEY_W];
    assign ent_value     = ent_rd_data[PW+1 +: chm_pkg::DATA_W];
    assign ent_link_live = ent_rd_data[PW];
    assign ent_link      = ent_rd_data[PW-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign s_beat  = s_valid && s_ready;

    chm_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .key       (s_data.key),
        .stat      (mod_stat),
        .remainder (bucket)
    );

    chm_ram #(
        .WIDTH (BW),
        .DEPTH (BUCKETS)
    ) u_bkt_ram (
        .aclk    (aclk),
        .wr_en   (bkt_wr_en),
        .wr_addr (bkt_wr_addr),
        .wr_data (bkt_wr_data),
        .rd_en   (bkt_rd_en),
        .rd_addr (bucket),
        .rd_data (bkt_rd_data)
    );

    chm_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_ENTRIES)
    ) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        data_next    = data_reg;
        sweep_next   = sweep_reg;
        fill_next    = fill_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        mod_start   = 1'b0;
        bkt_wr_en   = 1'b0;
        bkt_wr_addr = bucket;
        bkt_wr_data = {1'b1, fill_reg[PW-1:0]};
        bkt_rd_en   = 1'b0;
        ent_wr_en   = 1'b0;
        ent_wr_addr = fill_reg[PW-1:0];
        ent_wr_data = {key_reg, data_reg, bkt_live, bkt_head};
        ent_rd_en   = 1'b0;
        ent_rd_addr = bkt_head;

        // Drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                // Sweep every bucket to empty
                bkt_wr_en   = 1'b1;
                bkt_wr_addr = sweep_reg;
                bkt_wr_data = '0;
                sweep_next  = sweep_reg + RW'(1);
                if (sweep_reg == RW'(BUCKETS - 1)) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE: begin
                if (s_beat) begin
                    cmd_next  = s_data.command;
                    key_next  = s_data.key;
                    data_next = s_data.data_value;
                    res_next  = '0;
                    case (s_data.command)
                        chm_pkg::CMD_INSERT: begin
                            if (fill_reg == FW'(POOL_ENTRIES)) begin
                                res_next.status = chm_pkg::STATUS_FULL;
                                state_next      = ST_RESP;
                            end else begin
                                mod_start  = 1'b1;
                                state_next = ST_HASH;
                            end
                        end
                        chm_pkg::CMD_LOOKUP: begin
                            mod_start  = 1'b1;
                            state_next = ST_HASH;
                        end
                        chm_pkg::CMD_CLEAR: begin
                            fill_next  = '0;
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_HASH: begin
                // Read the bucket as soon as the remainder settles
                if (mod_stat.done) begin
                    bkt_rd_en  = 1'b1;
                    state_next = ST_BKT_CHK;
                end
            end
            ST_BKT_CHK: begin
                if (cmd_reg == chm_pkg::CMD_INSERT) begin
                    // Link the new entry at the head of the chain
                    ent_wr_en  = 1'b1;
                    bkt_wr_en  = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    state_next = ST_RESP;
                end else if (bkt_live) begin
                    ent_rd_en  = 1'b1;
                    state_next = ST_ENT_CHK;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_ENT_CHK: begin
                // Compare one chain entry, advance along the link
                if (ent_key == key_reg) begin
                    res_next.found      = 1'b1;
                    res_next.read_value = $signed(ent_value);
                    state_next          = ST_RESP;
                end else if (ent_link_live) begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = ent_link;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        data_reg   <= data_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Clear returns the whole pool on the next cycle
    a_clear_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_data.command == chm_pkg::CMD_CLEAR) |=> (fill_reg == '0))
        else $error("clear did not free the pool");

    // A linked insert takes exactly one pool slot
    a_insert_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BKT_CHK && cmd_reg == chm_pkg::CMD_INSERT)
        |=> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("insert did not advance the fill count");

    // Found is reported for lookups only
    a_found_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && res_reg.found) |-> (cmd_reg == chm_pkg::CMD_LOOKUP))
        else $error("found set on a non-lookup command");

    // Full status only when the pool is exhausted
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && res_reg.status)
        |-> (fill_reg == FW'(POOL_ENTRIES) && cmd_reg == chm_pkg::CMD_INSERT))
        else $error("full status with free pool slots");

    // The remainder unit finishes only while the sequencer waits for it
    a_mod_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_stat.done |-> (state_reg == ST_HASH))
        else $error("remainder finished outside the hash state");

    // The sequencer never waits on an idle remainder unit
    a_mod_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HASH) |-> (mod_stat.busy || mod_stat.done))
        else $error("hash state with idle remainder unit");

endmodule
